// File: src/pst_pkg.sv
// Package for the process slot table: table sizes, field widths, op and status codes.
// No dependencies; every other file refers to it by scoped names.
package pst_pkg;

   localparam int ENTRIES     = 16;
   localparam int ID_BITS     = 16;
   localparam int IDX_BITS    = $clog2(ENTRIES);
   localparam int OP_BITS     = 2;
   localparam int PID_BITS    = 16;
   localparam int STATUS_BITS = 2;
   localparam int SLOT_BITS   = 4;

   localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_BITS-1:0] OP_FIND   = 2'd1;
   localparam logic [OP_BITS-1:0] OP_REMOVE = 2'd2;

   localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd2;

endpackage

// File: src/pst_if.sv
// Valid/ready channel interfaces for the process slot table request and response.
// Depends on pst_pkg for field widths.
interface pst_req_if;
   logic                         valid;
   logic                         ready;
   logic [pst_pkg::OP_BITS-1:0]  op;
   logic [pst_pkg::PID_BITS-1:0] proc_id;
   logic [pst_pkg::PID_BITS-1:0] parent_ident;

   modport source (output valid, output op, output proc_id, output parent_ident,
                   input ready);
   modport sink   (input valid, input op, input proc_id, input parent_ident,
                   output ready);
endinterface

interface pst_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [pst_pkg::STATUS_BITS-1:0] status;
   logic [pst_pkg::SLOT_BITS-1:0]   slot;
   logic [pst_pkg::PID_BITS-1:0]    found_parent;

   modport source (output valid, output status, output slot, output found_parent,
                   input ready);
   modport sink   (input valid, input status, input slot, input found_parent,
                   output ready);
endinterface

// File: src/process_slot_table_top.sv
// Process slot table: insert into lowest free slot, find or remove by id.
// Depends on pst_pkg and the channel interfaces in pst_if.sv.
//
// channel  dir  payload                         transaction
// req      in   op, proc_id, parent_ident       valid && ready
// rsp      out  status, slot, found_parent      valid && ready
//
// A request is accepted, then scanned one slot per cycle through a single compare unit
// until the first hit (an unknown op skips the scan), then committed.
// Reset clears the used marks and control state; id and parent stores are not reset.
// The response sits in an output register; a stalled rsp holds the commit step
// but req is taken again as soon as the sequencer is idle.
module process_slot_table_top (
   input logic clock,
   input logic reset,
   pst_req_if.sink   req,
   pst_rsp_if.source rsp
);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_type;

   state_type                       state_ff, state_in;
   logic [pst_pkg::OP_BITS-1:0]     op_ff, op_in;
   logic [pst_pkg::ID_BITS-1:0]     key_ff, key_in;
   logic [pst_pkg::PID_BITS-1:0]    par_ff, par_in;
   logic [pst_pkg::IDX_BITS-1:0]    idx_ff, idx_in;
   logic                            hit_ff, hit_in;
   logic [pst_pkg::PID_BITS-1:0]    hit_par_ff, hit_par_in;
   logic [pst_pkg::ENTRIES-1:0]     used_ff, used_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [pst_pkg::STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic [pst_pkg::SLOT_BITS-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [pst_pkg::PID_BITS-1:0]    rsp_par_ff, rsp_par_in;

   logic [pst_pkg::ID_BITS-1:0]  id_ff  [pst_pkg::ENTRIES];
   logic [pst_pkg::PID_BITS-1:0] pid_ff [pst_pkg::ENTRIES];

   logic cur_used, match, out_free, commit, is_insert, last;

   assign is_insert = (op_ff == pst_pkg::OP_INSERT);
   assign cur_used  = used_ff[idx_ff];
   assign match     = is_insert ? !cur_used : (cur_used && id_ff[idx_ff] == key_ff);
   assign last      = (idx_ff == pst_pkg::IDX_BITS'(pst_pkg::ENTRIES - 1));
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign commit    = (state_ff == S_DONE) && out_free;

   assign req.ready        = (state_ff == S_IDLE);
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.slot         = rsp_slot_ff;
   assign rsp.found_parent = rsp_par_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      par_in        = par_ff;
      idx_in        = idx_ff;
      hit_in        = hit_ff;
      hit_par_in    = hit_par_ff;
      used_in       = used_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_par_in    = rsp_par_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               op_in  = req.op;
               key_in = pst_pkg::ID_BITS'(req.proc_id);
               par_in = req.parent_ident;
               idx_in = '0;
               hit_in = 1'b0;
               if (req.op == pst_pkg::OP_INSERT || req.op == pst_pkg::OP_FIND ||
                   req.op == pst_pkg::OP_REMOVE) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SCAN: begin
            if (match) begin
               hit_in     = 1'b1;
               hit_par_in = pid_ff[idx_ff];
               state_in   = S_DONE;
            end else if (last) begin
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (hit_ff) begin
                  rsp_status_in = pst_pkg::ST_OK;
                  rsp_slot_in   = pst_pkg::SLOT_BITS'(idx_ff);
                  rsp_par_in    = is_insert ? '0 : hit_par_ff;
                  if (is_insert) begin
                     used_in[idx_ff] = 1'b1;
                  end else if (op_ff == pst_pkg::OP_REMOVE) begin
                     used_in[idx_ff] = 1'b0;
                  end
               end else begin
                  rsp_status_in = is_insert ? pst_pkg::ST_FULL : pst_pkg::ST_NOT_FOUND;
                  rsp_slot_in   = '0;
                  rsp_par_in    = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_ff       <= hit_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      par_ff        <= par_in;
      idx_ff        <= idx_in;
      hit_par_ff    <= hit_par_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_par_ff    <= rsp_par_in;
   end

   always_ff @(posedge clock) begin
      if (commit && hit_ff && is_insert) begin
         id_ff[idx_ff]  <= key_ff;
         pid_ff[idx_ff] <= par_ff;
      end
   end

   // full status only when every slot is taken
   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      commit && is_insert && !hit_ff |-> &used_ff)
      else $error("insert reported full with a free slot");

   // find/remove hit lands on a used slot
   a_hit_is_used: assert property (@(posedge clock) disable iff (reset)
      commit && hit_ff && !is_insert |-> used_ff[idx_ff])
      else $error("lookup hit on a free slot");

   // insert marks its slot used
   a_insert_marks: assert property (@(posedge clock) disable iff (reset)
      commit && hit_ff && is_insert |=> used_ff[$past(idx_ff)])
      else $error("inserted slot not marked used");

   // failed responses carry zero slot and parent
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status != pst_pkg::ST_OK |-> rsp.slot == '0 && rsp.found_parent == '0)
      else $error("failed response with nonzero payload");

endmodule

// File: dv/process_slot_table_top_tb.sv
// Self-checking testbench for process_slot_table_top: insert, find, remove and unknown-op traffic
// checked against a behavioral slot table, under several sender and receiver idling phases.
// Depends on pst_pkg, pst_if.sv and the process_slot_table_top RTL.
module process_slot_table_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [pst_pkg::OP_BITS-1:0] OP_UNKNOWN = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 288;

   typedef struct packed {
      logic [pst_pkg::STATUS_BITS-1:0] status;
      logic [pst_pkg::SLOT_BITS-1:0]   slot;
      logic [pst_pkg::PID_BITS-1:0]    parent;
   } slot_result_type;

   class slot_table_scoreboard;
      bit                           used[pst_pkg::ENTRIES];
      logic [pst_pkg::ID_BITS-1:0]  ids[pst_pkg::ENTRIES];
      logic [pst_pkg::PID_BITS-1:0] parents[pst_pkg::ENTRIES];
      slot_result_type              expected_q[$];
      int                           errors;

      function new();
         errors = 0;
         foreach (used[i]) used[i] = 1'b0;
      endfunction

      function void note_request(logic [pst_pkg::OP_BITS-1:0] op,
                                 logic [pst_pkg::PID_BITS-1:0] proc_id,
                                 logic [pst_pkg::PID_BITS-1:0] parent_ident);
         logic [pst_pkg::ID_BITS-1:0] key;
         slot_result_type             res;
         int                          hit;
         key = proc_id[pst_pkg::ID_BITS-1:0];
         res = '{status: pst_pkg::ST_NOT_FOUND, slot: '0, parent: '0};
         hit = -1;
         case (op) inside
            pst_pkg::OP_INSERT: begin
               for (int i = 0; i < pst_pkg::ENTRIES; i++)
                  if (hit < 0 && !used[i]) hit = i;
               if (hit < 0) begin
                  res.status = pst_pkg::ST_FULL;
               end else begin
                  used[hit]    = 1'b1;
                  ids[hit]     = key;
                  parents[hit] = parent_ident;
                  res.status   = pst_pkg::ST_OK;
                  res.slot     = pst_pkg::SLOT_BITS'(hit);
               end
            end
            pst_pkg::OP_FIND, pst_pkg::OP_REMOVE: begin
               for (int i = 0; i < pst_pkg::ENTRIES; i++)
                  if (hit < 0 && used[i] && ids[i] == key) hit = i;
               if (hit >= 0) begin
                  res.status = pst_pkg::ST_OK;
                  res.slot   = pst_pkg::SLOT_BITS'(hit);
                  res.parent = parents[hit];
                  if (op == pst_pkg::OP_REMOVE) used[hit] = 1'b0;
               end
            end
            default: ;
         endcase
         expected_q.push_back(res);
      endfunction

      function void check_response(logic [pst_pkg::STATUS_BITS-1:0] status,
                                   logic [pst_pkg::SLOT_BITS-1:0] slot,
                                   logic [pst_pkg::PID_BITS-1:0] found_parent);
         slot_result_type exp_res;
         if (expected_q.size() == 0) begin
            $error("unexpected response transaction: status=%0d slot=%0d found_parent=%h",
                   status, slot, found_parent);
            errors++;
            return;
         end
         exp_res = expected_q.pop_front();
         if (status !== exp_res.status) begin
            $error("status: expected %0d, actual %0d", exp_res.status, status);
            errors++;
         end
         if (slot !== exp_res.slot) begin
            $error("slot: expected %0d, actual %0d", exp_res.slot, slot);
            errors++;
         end
         if (found_parent !== exp_res.parent) begin
            $error("found_parent: expected %h, actual %h", exp_res.parent, found_parent);
            errors++;
         end
      endfunction

      function logic [pst_pkg::PID_BITS-1:0] live_id();
         int picks[$];
         for (int i = 0; i < pst_pkg::ENTRIES; i++)
            if (used[i]) picks.push_back(i);
         if (picks.size() == 0) return pst_pkg::PID_BITS'($urandom);
         return pst_pkg::PID_BITS'(ids[picks[$urandom_range(picks.size() - 1)]]);
      endfunction
   endclass

   logic clock;
   logic reset;
   int   idle_pct;
   int   stall_pct;
   int   cycle_count;
   logic [pst_pkg::PID_BITS-1:0] id_pool[16];
   slot_table_scoreboard sb;

   pst_req_if req();
   pst_rsp_if rsp();

   process_slot_table_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("process_slot_table_top_tb: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         sb.check_response(rsp.status, rsp.slot, rsp.found_parent);
   end

   task automatic send_req(logic [pst_pkg::OP_BITS-1:0] op,
                           logic [pst_pkg::PID_BITS-1:0] proc_id,
                           logic [pst_pkg::PID_BITS-1:0] parent_ident);
      while ($urandom_range(99) < idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid        <= 1'b1;
      req.op           <= op;
      req.proc_id      <= proc_id;
      req.parent_ident <= parent_ident;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sb.note_request(op, proc_id, parent_ident);
   endtask

   function automatic logic [pst_pkg::PID_BITS-1:0] pick_id();
      if ($urandom_range(99) < 75) return id_pool[$urandom_range(15)];
      return pst_pkg::PID_BITS'($urandom);
   endfunction

   task automatic directed_requests();
      send_req(pst_pkg::OP_FIND, 16'h0000, 16'h0000);
      send_req(pst_pkg::OP_INSERT, 16'hFFFF, 16'hFFFF);
      send_req(pst_pkg::OP_INSERT, 16'hFFFF, 16'hABCD);
      send_req(pst_pkg::OP_FIND, 16'hFFFF, 16'h0000);
      send_req(pst_pkg::OP_REMOVE, 16'hFFFF, 16'h5555);
      send_req(pst_pkg::OP_FIND, 16'hFFFF, 16'h0000);
      send_req(OP_UNKNOWN, 16'hFFFF, 16'hFFFF);
      // fill the table, then overflow it
      for (int i = 0; i < pst_pkg::ENTRIES - 1; i++)
         send_req(pst_pkg::OP_INSERT, pst_pkg::PID_BITS'(i * 16'h1111),
                  pst_pkg::PID_BITS'(16'hFFFF - i * 16'h1111));
      send_req(pst_pkg::OP_INSERT, 16'h7E57, 16'h8001);
      send_req(pst_pkg::OP_REMOVE, 16'h0000, 16'h0000);
      send_req(pst_pkg::OP_REMOVE, 16'h0000, 16'h0000);
   endtask

   task automatic random_requests(int count, inout int seq);
      logic [pst_pkg::OP_BITS-1:0]  op;
      logic [pst_pkg::PID_BITS-1:0] proc_id;
      logic [pst_pkg::PID_BITS-1:0] parent_ident;
      int r;
      int ins_pct;
      for (int n = 0; n < count; n++) begin
         // alternate fill and drain stretches so the table swings between empty and full
         ins_pct      = ((seq / 64) % 2 == 0) ? 68 : 24;
         r            = $urandom_range(99);
         parent_ident = pst_pkg::PID_BITS'($urandom);
         if (r < 3) begin
            op      = OP_UNKNOWN;
            proc_id = pst_pkg::PID_BITS'($urandom);
         end else if (r < 3 + ins_pct) begin
            op      = pst_pkg::OP_INSERT;
            proc_id = pick_id();
         end else begin
            op      = $urandom_range(1) ? pst_pkg::OP_REMOVE : pst_pkg::OP_FIND;
            proc_id = ($urandom_range(99) < 70) ? sb.live_id() : pick_id();
         end
         send_req(op, proc_id, parent_ident);
         seq++;
      end
   endtask

   initial begin
      int seq;
      sb               = new();
      seq              = 0;
      cycle_count      = 0;
      idle_pct         = 0;
      stall_pct        = 0;
      reset            = 1'b1;
      req.valid        = 1'b0;
      req.op           = pst_pkg::OP_INSERT;
      req.proc_id      = '0;
      req.parent_ident = '0;
      rsp.ready        = 1'b0;
      foreach (id_pool[i]) id_pool[i] = pst_pkg::PID_BITS'($urandom);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed_requests();

      idle_pct = 0;  stall_pct = 0;
      random_requests(PHASE_ITEMS, seq);
      idle_pct = 52; stall_pct = 0;
      random_requests(PHASE_ITEMS, seq);
      idle_pct = 0;  stall_pct = 52;
      random_requests(PHASE_ITEMS, seq);
      idle_pct = 36; stall_pct = 36;
      random_requests(PHASE_ITEMS, seq);
      req.valid <= 1'b0;

      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (pst_pkg::ENTRIES + 4) @(posedge clock);
      if (sb.errors == 0) begin
         $display("process_slot_table_top_tb: done, clean");
      end else begin
         $display("process_slot_table_top_tb: done, errors");
      end
      $finish;
   end

endmodule

// File: files.f
src/pst_pkg.sv
src/pst_if.sv
src/process_slot_table_top.sv
dv/process_slot_table_top_tb.sv
